>>> rtl/core/ancillary_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Ancillary packet deframer assertion macros
// Shared concurrent assertion forms on i_clk, reset disabled or not.
// ----------------------------------------------------------------------------
`ifndef ANCILLARY_PACKET_DEFRAMER_DEFINES_SVH
`define ANCILLARY_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, off while in reset
`define APD_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication, off while in reset
`define APD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

// next-cycle implication, checked through reset
`define APD_ASSERT_NEXT_RST(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) (cond) |=> (conseq)) else $error(msg);

`endif

>>> rtl/core/apd_pkg.sv
// ----------------------------------------------------------------------------
// Ancillary packet deframer package
// Widths, reset values, parse phases and result kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apd_pkg;

    localparam int unsigned WORD_W  = 10;
    localparam int unsigned POS_W   = 14;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SUM_W   = 9;
    localparam int unsigned KIND_W  = 3;

    localparam logic [POS_W-1:0] LINE_WORDS_RST = 14'd3840;
    localparam logic [POS_W-1:0] POS_MAX        = 14'h3fff;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_DID    = 3'd1,
        PH_SDID   = 3'd2,
        PH_DC     = 3'd3,
        PH_USER   = 3'd4,
        PH_CSUM   = 3'd5
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER   = 3'd0,
        KIND_USER     = 3'd1,
        KIND_CSUM_OK  = 3'd2,
        KIND_CSUM_BAD = 3'd3,
        KIND_TOO_LONG = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        FLAG_NONE = 2'd0,
        FLAG_ONE  = 2'd1,
        FLAG_TWO  = 2'd2
    } t_flag;

endpackage

>>> rtl/core/apd_in_if.sv
// ----------------------------------------------------------------------------
// Ancillary packet deframer input channel
// One SDI word per item with a line start marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apd_in_if import apd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              line_start;

    modport source (output valid, output word, output line_start, input ready);
    modport sink   (input valid, input word, input line_start, output ready);
endinterface

>>> rtl/core/apd_out_if.sv
// ----------------------------------------------------------------------------
// Ancillary packet deframer result channel
// Header, user word and end-of-packet items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apd_out_if import apd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_id;
    logic [BYTE_W-1:0] secondary_id;
    logic [BYTE_W-1:0] data_count;
    logic [WORD_W-1:0] payload_word;
    logic [BYTE_W-1:0] payload_index;
    logic [POS_W-1:0]  packet_offset;
    logic              last;

    modport source (output valid, output kind, output data_id, output secondary_id,
                    output data_count, output payload_word, output payload_index,
                    output packet_offset, output last, input ready);
    modport sink   (input valid, input kind, input data_id, input secondary_id,
                    input data_count, input payload_word, input payload_index,
                    input packet_offset, input last, output ready);
endinterface

>>> rtl/core/apd_cfg_if.sv
// ----------------------------------------------------------------------------
// Ancillary packet deframer configuration channel
// Write channel for the line length register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apd_cfg_if import apd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ancillary_packet_deframer.sv
// ----------------------------------------------------------------------------
// Ancillary packet deframer
// Finds ancillary data flags in a line of SDI words and parses the packets.
// ----------------------------------------------------------------------------
// i_in takes one 10-bit SDI word per item, line_start on the first word of
// each line. i_cfg writes line_words (words per line); it is always ready.
// o_out gives zero or one result per word: a header on the DC word, one item
// per user word, then checksum good/bad, or packet too long (then the rest of
// the line is skipped). last marks the final result of a packet.
// A word is held in the input register, parsed, and its result is written
// to the result register for o_out. Throughput: one word per cycle while o_out
// is not stalled; the parse step is a single pass between the two registers.
// When the receiver stalls with a result pending, the input register holds
// one more word and then i_in.ready drops until the result is taken.
// Reset: line_words returns to 3840, both registers empty, parsing restarts
// in search with scanning enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ancillary_packet_deframer
    import apd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    apd_in_if.sink   i_in,
    apd_cfg_if.sink  i_cfg,
    apd_out_if.source o_out
);

    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_word;
    logic              r_s1_ls;

    logic [POS_W-1:0]  r_line_words;
    logic [POS_W-1:0]  r_position,   n_position;
    t_flag             r_flag,       n_flag;
    t_phase            r_phase,      n_phase;
    logic [BYTE_W-1:0] r_data_id,    n_data_id;
    logic [BYTE_W-1:0] r_sec_id,     n_sec_id;
    logic [BYTE_W-1:0] r_count,      n_count;
    logic [BYTE_W-1:0] r_left,       n_left;
    logic [SUM_W-1:0]  r_sum,        n_sum;
    logic [POS_W-1:0]  r_offset,     n_offset;
    logic              r_stopped,    n_stopped;

    logic              r_out_valid;
    t_kind             r_kind,       n_kind;
    logic [WORD_W-1:0] r_pword,      n_pword;
    logic [BYTE_W-1:0] r_pindex,     n_pindex;
    logic              r_last,       n_last;
    logic [BYTE_W-1:0] r_o_data_id;
    logic [BYTE_W-1:0] r_o_sec_id;
    logic [BYTE_W-1:0] r_o_count;
    logic [POS_W-1:0]  r_o_offset;

    logic              advance;
    logic              proc;
    logic              res;
    logic [POS_W-1:0]  pos;
    t_flag             cur_flag;
    t_phase            cur_phase;
    logic              cur_stopped;
    logic [BYTE_W-1:0] top;
    logic [SUM_W-1:0]  w9;
    logic [POS_W:0]    flag_end;
    logic [POS_W:0]    pkt_end;
    logic [WORD_W-1:0] expect_cs;

    assign advance     = !r_out_valid || o_out.ready;
    assign proc        = r_s1_valid && advance;
    assign i_in.ready  = !r_s1_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign pos         = r_s1_ls ? '0 : r_position;
    assign cur_flag    = r_s1_ls ? FLAG_NONE : r_flag;
    assign cur_phase   = r_s1_ls ? PH_SEARCH : r_phase;
    assign cur_stopped = r_s1_ls ? 1'b0 : r_stopped;
    assign top         = r_s1_word[WORD_W-1:2];
    assign w9          = r_s1_word[SUM_W-1:0];
    assign flag_end    = {1'b0, pos} + (POS_W+1)'(5);
    assign pkt_end     = {1'b0, r_offset} + {{(POS_W+1-BYTE_W){1'b0}}, r_s1_word[BYTE_W-1:0]}
                         + (POS_W+1)'(3);
    assign expect_cs   = {~r_sum[SUM_W-1], r_sum};

    always_comb begin
        n_position = (pos != POS_MAX) ? pos + POS_W'(1) : pos;
        n_flag     = cur_flag;
        n_phase    = cur_phase;
        n_stopped  = cur_stopped;
        n_data_id  = r_data_id;
        n_sec_id   = r_sec_id;
        n_count    = r_count;
        n_left     = r_left;
        n_sum      = r_sum;
        n_offset   = r_offset;
        res        = 1'b0;
        n_kind     = KIND_HEADER;
        n_pword    = '0;
        n_pindex   = '0;
        n_last     = 1'b0;
        if (!cur_stopped) begin
            case (cur_phase)
                PH_SEARCH: begin
                    if (cur_flag == FLAG_TWO && top == 8'hff) begin
                        n_flag = FLAG_NONE;
                        if (flag_end < {1'b0, r_line_words}) begin
                            n_phase = PH_DID;
                        end
                    end else if (cur_flag == FLAG_ONE && top == 8'hff) begin
                        n_flag = FLAG_TWO;
                    end else if (top == 8'h00) begin
                        n_flag = FLAG_ONE;
                    end else begin
                        n_flag = FLAG_NONE;
                    end
                end
                PH_DID: begin
                    n_data_id = r_s1_word[BYTE_W-1:0];
                    n_sum     = w9;
                    n_offset  = pos;
                    n_phase   = PH_SDID;
                end
                PH_SDID: begin
                    n_sec_id = r_s1_word[BYTE_W-1:0];
                    n_sum    = r_sum + w9;
                    n_phase  = PH_DC;
                end
                PH_DC: begin
                    n_count = r_s1_word[BYTE_W-1:0];
                    res     = 1'b1;
                    if (pkt_end >= {1'b0, r_line_words}) begin
                        n_kind    = KIND_TOO_LONG;
                        n_last    = 1'b1;
                        n_stopped = 1'b1;
                        n_phase   = PH_SEARCH;
                        n_flag    = FLAG_NONE;
                    end else begin
                        n_sum   = r_sum + w9;
                        n_left  = r_s1_word[BYTE_W-1:0];
                        n_kind  = KIND_HEADER;
                        n_phase = (r_s1_word[BYTE_W-1:0] != '0) ? PH_USER : PH_CSUM;
                    end
                end
                PH_USER: begin
                    n_sum    = r_sum + w9;
                    res      = 1'b1;
                    n_kind   = KIND_USER;
                    n_pword  = r_s1_word;
                    n_pindex = r_count - r_left;
                    n_left   = r_left - BYTE_W'(1);
                    if (r_left == BYTE_W'(1)) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    res     = 1'b1;
                    n_kind  = (r_s1_word == expect_cs) ? KIND_CSUM_OK : KIND_CSUM_BAD;
                    n_last  = 1'b1;
                    n_phase = PH_SEARCH;
                    n_flag  = FLAG_NONE;
                end
                default: begin
                    n_phase = PH_SEARCH;
                    n_flag  = FLAG_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
        end else if (proc) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_words <= LINE_WORDS_RST;
            r_position   <= '0;
            r_flag       <= FLAG_NONE;
            r_stopped    <= 1'b0;
            r_data_id    <= '0;
            r_sec_id     <= '0;
            r_count      <= '0;
            r_left       <= '0;
            r_sum        <= '0;
            r_offset     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_line_words <= i_cfg.data;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= proc && res;
            end
            if (proc) begin
                r_position <= n_position;
                r_flag     <= n_flag;
                r_stopped  <= n_stopped;
                r_data_id  <= n_data_id;
                r_sec_id   <= n_sec_id;
                r_count    <= n_count;
                r_left     <= n_left;
                r_sum      <= n_sum;
                r_offset   <= n_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_word <= i_in.word;
            r_s1_ls   <= i_in.line_start;
        end
        if (proc) begin
            r_kind      <= n_kind;
            r_pword     <= n_pword;
            r_pindex    <= n_pindex;
            r_last      <= n_last;
            r_o_data_id <= n_data_id;
            r_o_sec_id  <= n_sec_id;
            r_o_count   <= n_count;
            r_o_offset  <= n_offset;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.data_id       = r_o_data_id;
    assign o_out.secondary_id  = r_o_sec_id;
    assign o_out.data_count    = r_o_count;
    assign o_out.payload_word  = r_pword;
    assign o_out.payload_index = r_pindex;
    assign o_out.packet_offset = r_o_offset;
    assign o_out.last          = r_last;

endmodule

>>> rtl/core/apd_chk.sv
// ----------------------------------------------------------------------------
// Ancillary packet deframer port checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ancillary_packet_deframer_defines.svh"

module apd_chk
    import apd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [KIND_W-1:0] i_out_kind,
    input logic [WORD_W-1:0] i_out_pword,
    input logic              i_out_last
);

    // stalled result holds
    `APD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_kind) && $stable(i_out_pword) && $stable(i_out_last),
        "stalled result changed")

    `APD_ASSERT_NEXT_RST(a_rst_empty, !i_rst_n, !i_out_valid,
        "result valid right after reset")

    // end of packet is never directly followed by another result
    `APD_ASSERT_NEXT(a_gap_after_last, i_out_valid && i_out_ready && i_out_last,
        !i_out_valid, "result right after end of packet")

    `APD_ASSERT_NOW(a_in_stall_cause, !i_in_ready, i_out_valid && !i_out_ready,
        "input stalled without output backpressure")

endmodule

bind ancillary_packet_deframer apd_chk u_apd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_pword (o_out.payload_word),
    .i_out_last  (o_out.last)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Ancillary packet deframer testbench
// Streams SDI blanking lines with ancillary packets (good, bad, truncated,
// oversized) into the deframer under several line lengths. A built-in
// parser model predicts every header, user word and end item, and the
// monitor checks them in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import apd_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              ls;
    } t_sdi_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_id;
        logic [BYTE_W-1:0] secondary_id;
        logic [BYTE_W-1:0] data_count;
        logic [WORD_W-1:0] payload_word;
        logic [BYTE_W-1:0] payload_index;
        logic [POS_W-1:0]  packet_offset;
        logic              last;
    } t_anc_result;

    logic i_clk;
    logic i_rst_n;

    apd_in_if  in_bus ();
    apd_cfg_if cfg_bus ();
    apd_out_if out_bus ();

    ancillary_packet_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    t_sdi_item   sdi_words[$];
    t_anc_result expected_results[$];
    t_sdi_item   next_word;

    int unsigned words_queued;
    int unsigned words_accepted;
    int unsigned line_fill;
    int unsigned fail_count;
    int unsigned in_gap;
    int unsigned out_stall;
    int unsigned hold_left;
    bit          hold_done;
    bit          idle_on;

    // parser model state
    logic [POS_W-1:0]  line_len;
    logic [POS_W-1:0]  pos_r;
    t_flag             flag_r;
    t_phase            phase_r;
    logic [BYTE_W-1:0] did_r;
    logic [BYTE_W-1:0] sdid_r;
    logic [BYTE_W-1:0] count_r;
    logic [BYTE_W-1:0] left_r;
    logic [SUM_W-1:0]  sum_r;
    logic [POS_W-1:0]  offset_r;
    logic              stopped_r;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic post_result(t_kind k, logic [WORD_W-1:0] pw, logic [BYTE_W-1:0] pi,
                               logic lst);
        t_anc_result r;
        r.kind          = k;
        r.data_id       = did_r;
        r.secondary_id  = sdid_r;
        r.data_count    = count_r;
        r.payload_word  = pw;
        r.payload_index = pi;
        r.packet_offset = offset_r;
        r.last          = lst;
        expected_results.push_back(r);
    endtask

    task automatic deframe_word(logic [WORD_W-1:0] w, logic ls);
        logic [7:0]        top;
        logic [POS_W-1:0]  pos;
        logic [SUM_W-1:0]  sum_now;
        logic [WORD_W-1:0] want_cs;
        top = w[9:2];
        if (ls) begin
            pos_r     = '0;
            flag_r    = FLAG_NONE;
            phase_r   = PH_SEARCH;
            stopped_r = 1'b0;
        end
        pos = pos_r;
        if (pos_r != POS_MAX) pos_r = pos_r + 1'b1;
        if (!stopped_r) begin
            case (phase_r)
                PH_SEARCH: begin
                    if (flag_r == FLAG_TWO && top == 8'hff) begin
                        flag_r = FLAG_NONE;
                        if (int'(pos) + 5 < int'(line_len)) phase_r = PH_DID;
                    end else if (flag_r == FLAG_ONE && top == 8'hff) begin
                        flag_r = FLAG_TWO;
                    end else if (top == 8'h00) begin
                        flag_r = FLAG_ONE;
                    end else begin
                        flag_r = FLAG_NONE;
                    end
                end
                PH_DID: begin
                    did_r    = w[7:0];
                    sum_r    = w[8:0];
                    offset_r = pos;
                    phase_r  = PH_SDID;
                end
                PH_SDID: begin
                    sdid_r  = w[7:0];
                    sum_r   = sum_r + w[8:0];
                    phase_r = PH_DC;
                end
                PH_DC: begin
                    count_r = w[7:0];
                    if (int'(offset_r) + int'(count_r) + 3 >= int'(line_len)) begin
                        post_result(KIND_TOO_LONG, '0, '0, 1'b1);
                        stopped_r = 1'b1;
                        phase_r   = PH_SEARCH;
                        flag_r    = FLAG_NONE;
                    end else begin
                        sum_r  = sum_r + w[8:0];
                        left_r = count_r;
                        post_result(KIND_HEADER, '0, '0, 1'b0);
                        phase_r = (count_r != 0) ? PH_USER : PH_CSUM;
                    end
                end
                PH_USER: begin
                    sum_r = sum_r + w[8:0];
                    post_result(KIND_USER, w, count_r - left_r, 1'b0);
                    left_r = left_r - 1'b1;
                    if (left_r == 0) phase_r = PH_CSUM;
                end
                default: begin
                    sum_now = sum_r;
                    want_cs = {~sum_now[8], sum_now};
                    post_result((w == want_cs) ? KIND_CSUM_OK : KIND_CSUM_BAD, '0, '0, 1'b1);
                    phase_r = PH_SEARCH;
                    flag_r  = FLAG_NONE;
                end
            endcase
        end
    endtask

    task automatic put_word(logic [WORD_W-1:0] w, logic ls);
        t_sdi_item it;
        it.word = w;
        it.ls   = ls;
        sdi_words.push_back(it);
        words_queued++;
        line_fill++;
    endtask

    // keep < 0 sends the whole packet, else only that many words after the flag
    task automatic put_packet(bit ls_first, logic [WORD_W-1:0] did_w, logic [WORD_W-1:0] sdid_w,
                              logic [WORD_W-1:0] dc_w, bit corrupt, int keep);
        logic [WORD_W-1:0] body[$];
        logic [WORD_W-1:0] uw;
        logic [SUM_W-1:0]  s;
        s = did_w[8:0] + sdid_w[8:0] + dc_w[8:0];
        body.push_back(did_w);
        body.push_back(sdid_w);
        body.push_back(dc_w);
        for (int i = 0; i < int'(dc_w[7:0]); i++) begin
            uw = WORD_W'($urandom_range(0, 1023));
            s  = s + uw[8:0];
            body.push_back(uw);
        end
        uw = {~s[8], s};
        if (corrupt) uw = uw ^ WORD_W'($urandom_range(1, 1023));
        body.push_back(uw);
        put_word({8'h00, 2'($urandom_range(0, 3))}, ls_first);
        put_word({8'hff, 2'($urandom_range(0, 3))}, 1'b0);
        put_word({8'hff, 2'($urandom_range(0, 3))}, 1'b0);
        for (int i = 0; i < body.size(); i++) begin
            if (keep >= 0 && i >= keep) break;
            put_word(body[i], 1'b0);
        end
    endtask

    task automatic put_random_packet(bit ls_first);
        int unsigned r;
        int unsigned dc;
        int          keep;
        r = $urandom_range(0, 99);
        if (r < 85) dc = $urandom_range(0, 6);
        else if (r < 95) dc = $urandom_range(7, 40);
        else dc = $urandom_range(41, 255);
        keep = ($urandom_range(0, 99) < 10) ? int'($urandom_range(0, dc + 3)) : -1;
        put_packet(ls_first, WORD_W'($urandom_range(0, 1023)), WORD_W'($urandom_range(0, 1023)),
                   {2'($urandom_range(0, 3)), 8'(dc)}, $urandom_range(0, 99) < 15, keep);
    endtask

    task automatic put_line(int unsigned lw);
        int unsigned target;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) target = lw;
        else if (r < 90) target = $urandom_range(1, lw);
        else target = lw + $urandom_range(1, 20);
        if (target > 300) target = $urandom_range(20, 300);
        line_fill = 0;
        if ($urandom_range(0, 3) == 0) put_random_packet(1'b1);
        else put_word(WORD_W'($urandom_range(0, 1023)), 1'b1);
        while (line_fill < target) begin
            if ($urandom_range(0, 99) < 55) begin
                put_random_packet(1'b0);
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    put_word({8'h00, 2'($urandom_range(0, 3))}, 1'b0);
                    put_word({8'hff, 2'($urandom_range(0, 3))}, 1'b0);
                end
                repeat ($urandom_range(1, 5)) put_word(WORD_W'($urandom_range(0, 1023)), 1'b0);
            end
        end
    endtask

    task automatic wait_drained();
        while (words_accepted != words_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_line_words(logic [POS_W-1:0] v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        line_len = v;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            in_gap       <= 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                deframe_word(in_bus.word, in_bus.line_start);
                words_accepted++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (in_gap != 0) begin
                    in_gap       <= in_gap - 1;
                    in_bus.valid <= 1'b0;
                end else if (sdi_words.size() != 0 && idle_on && $urandom_range(0, 99) < 20) begin
                    in_gap       <= gap_len();
                    in_bus.valid <= 1'b0;
                end else if (sdi_words.size() != 0) begin
                    next_word         = sdi_words.pop_front();
                    in_bus.word       <= next_word.word;
                    in_bus.line_start <= next_word.ls;
                    in_bus.valid      <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once traffic is flowing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_accepted >= 300 && sdi_words.size() > 20) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_anc_result got;
        t_anc_result want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            out_stall     <= 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got.kind          = out_bus.kind;
                got.data_id       = out_bus.data_id;
                got.secondary_id  = out_bus.secondary_id;
                got.data_count    = out_bus.data_count;
                got.payload_word  = out_bus.payload_word;
                got.payload_index = out_bus.payload_index;
                got.packet_offset = out_bus.packet_offset;
                got.last          = out_bus.last;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 50)
                        $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 50)
                            $display("%0t: result mismatch exp %p got %p", $time, want, got);
                    end
                end
            end
            if (out_stall != 0) begin
                out_stall     <= out_stall - 1;
                out_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 20) begin
                out_stall     <= gap_len() - 1;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= (hold_left == 0);
            end
        end
    end

    initial begin
        int unsigned lw_set[8];
        int unsigned lw;
        int unsigned phase_start;
        in_bus.valid      = 1'b0;
        in_bus.word       = '0;
        in_bus.line_start = 1'b0;
        out_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.data      = '0;
        i_rst_n           = 1'b0;
        idle_on           = 1'b1;
        words_queued      = 0;
        words_accepted    = 0;
        fail_count        = 0;
        line_len          = LINE_WORDS_RST;
        pos_r             = '0;
        flag_r            = FLAG_NONE;
        phase_r           = PH_SEARCH;
        did_r             = '0;
        sdid_r            = '0;
        count_r           = '0;
        left_r            = '0;
        sum_r             = '0;
        offset_r          = '0;
        stopped_r         = 1'b0;
        lw_set            = '{8, 16383, 23, 3840, 64, 0, 150, 0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme ids, empty packet, bad checksum, cut by a new line
        put_packet(1'b1, 10'h3ff, 10'h000, 10'h200, 1'b0, -1);
        put_packet(1'b0, 10'h000, 10'h3ff, 10'h301, 1'b1, -1);
        put_packet(1'b0, 10'h155, 10'h2aa, 10'h001, 1'b0, 3);
        put_packet(1'b1, 10'h0ff, 10'h100, 10'h0ff, 1'b0, 4);
        put_packet(1'b1, 10'h1ff, 10'h2ff, 10'h101, 1'b0, -1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            lw = lw_set[p];
            if (lw == 0) lw = $urandom_range(8, 300);
            write_line_words(POS_W'(lw));
            idle_on     = (p != 3);
            phase_start = words_queued;
            while (words_queued - phase_start < 60) put_line(lw);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
